// ----- sv/clx_pkg.sv -----
package clx_pkg;

    // Token kinds.
    localparam logic [4:0] K_INT     = 5'd0;
    localparam logic [4:0] K_FLOAT   = 5'd1;
    localparam logic [4:0] K_CHAR    = 5'd2;
    localparam logic [4:0] K_ID      = 5'd3;
    localparam logic [4:0] K_NUM     = 5'd4;
    localparam logic [4:0] K_CHARLIT = 5'd5;
    localparam logic [4:0] K_ASSIGN  = 5'd6;
    localparam logic [4:0] K_PRINT   = 5'd7;
    localparam logic [4:0] K_IF      = 5'd8;
    localparam logic [4:0] K_WHILE   = 5'd9;
    localparam logic [4:0] K_LPAREN  = 5'd10;
    localparam logic [4:0] K_RPAREN  = 5'd11;
    localparam logic [4:0] K_LBRACE  = 5'd12;
    localparam logic [4:0] K_RBRACE  = 5'd13;
    localparam logic [4:0] K_PLUS    = 5'd14;
    localparam logic [4:0] K_MINUS   = 5'd15;
    localparam logic [4:0] K_STAR    = 5'd16;
    localparam logic [4:0] K_SLASH   = 5'd17;
    localparam logic [4:0] K_SEMI    = 5'd18;
    localparam logic [4:0] K_EQ      = 5'd19;
    localparam logic [4:0] K_NE      = 5'd20;
    localparam logic [4:0] K_LT      = 5'd21;
    localparam logic [4:0] K_GT      = 5'd22;
    localparam logic [4:0] K_LE      = 5'd23;
    localparam logic [4:0] K_GE      = 5'd24;
    localparam logic [4:0] K_END     = 5'd25;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Pending operator codes.
    localparam logic [1:0] OP_EQUAL = 2'd0;
    localparam logic [1:0] OP_BANG  = 2'd1;
    localparam logic [1:0] OP_LT    = 2'd2;
    localparam logic [1:0] OP_GT    = 2'd3;

    // Keyword prefixes, first character in the low byte.
    localparam logic [39:0] KW_INT   = 40'h00_00_74_6E_69;
    localparam logic [39:0] KW_FLOAT = 40'h74_61_6F_6C_66;
    localparam logic [39:0] KW_CHAR  = 40'h00_72_61_68_63;
    localparam logic [39:0] KW_PRINT = 40'h74_6E_69_72_70;
    localparam logic [39:0] KW_IF    = 40'h00_00_00_66_69;
    localparam logic [39:0] KW_WHILE = 40'h65_6C_69_68_77;

    typedef struct packed {
        logic [4:0]  kind;
        logic [11:0] start_res;
        logic [5:0]  length;
        logic        overlong;
        logic        last;
    } t_token;

    // Up to two tokens produced by one character.
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token t0;
        t_token t1;
    } t_emit;

    function automatic t_token mk_token(input logic [4:0] kind, input logic [11:0] start,
                                        input logic [5:0] len, input logic ovf,
                                        input logic last);
        t_token t;
        t.kind      = kind;
        t.start_res = start;
        t.length    = len;
        t.overlong  = ovf;
        t.last      = last;
        return t;
    endfunction

    // Kind of an operator followed by '='.
    function automatic logic [4:0] pair_kind(input logic [1:0] op);
        logic [4:0] k;
        unique case (op)
            OP_EQUAL: k = K_EQ;
            OP_BANG:  k = K_NE;
            OP_LT:    k = K_LE;
            OP_GT:    k = K_GE;
            default:  k = K_END;
        endcase
        return k;
    endfunction

    // Kind of an operator standing alone.
    function automatic logic [4:0] single_kind(input logic [1:0] op);
        logic [4:0] k;
        unique case (op)
            OP_EQUAL: k = K_ASSIGN;
            OP_BANG:  k = K_END;
            OP_LT:    k = K_LT;
            OP_GT:    k = K_GT;
            default:  k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ----- sv/clx_if.sv -----
// Character channel: one source character per item.
interface clx_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source(output valid, output ch, input ready);
    modport sink(input valid, input ch, output ready);
endinterface

// Token channel: one token per item.
interface clx_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  kind;
    logic [11:0] start_res;
    logic [5:0]  length;
    logic        overlong;
    logic        last;

    modport source(output valid, output kind, output start_res, output length,
                   output overlong, output last, input ready);
    modport sink(input valid, input kind, input start_res, input length,
                 input overlong, input last, output ready);
endinterface

// ----- sv/clx_core.sv -----
module clx_core
    import clx_pkg::*;
#(
    parameter int TEXT_MAX   = 4096,
    parameter int LEXEME_CAP = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    output t_emit      o_emit
);

    localparam int PW      = $clog2(TEXT_MAX);
    localparam int LW      = $clog2(LEXEME_CAP + 1);
    localparam int CAP_OUT = (LEXEME_CAP > 63) ? 63 : LEXEME_CAP;

    typedef enum logic [2:0] {
        M_IDLE,
        M_NUM,
        M_IDENT,
        M_QUOTE,
        M_SKIP,
        M_OP
    } t_mode;

    t_mode          r_mode,          n_mode;
    logic [1:0]     r_pending_op,    n_pending_op;
    logic           r_seen_dot,      n_seen_dot;
    logic [PW-1:0]  r_token_start,   n_token_start;
    logic [LW-1:0]  r_token_length,  n_token_length;
    logic           r_overflow,      n_overflow;
    logic [39:0]    r_prefix,        n_prefix;
    logic [PW-1:0]  r_position,      n_position;

    logic [7:0]     len8;
    logic [5:0]     sat_len;
    logic           sat_ovf;
    logic [LW-1:0]  grow_len;
    logic           grow_ovf;
    logic [39:0]    grow_prefix;
    logic [11:0]    at12;
    logic [11:0]    start12;
    logic [4:0]     id_kind;
    logic           close_v;
    t_token         close_tok;
    logic           do_idle;
    logic           idle_v;
    t_token         idle_tok;

    function automatic logic [11:0] low12(input logic [PW-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return w[11:0];
    endfunction

    assign at12    = low12(r_position);
    assign start12 = low12(r_token_start);
    assign len8    = 8'(r_token_length);

    // Length as reported, saturated at the output cap.
    always_comb begin
        if (len8 > 8'(CAP_OUT)) begin
            sat_len = 6'(CAP_OUT);
            sat_ovf = 1'b1;
        end else begin
            sat_len = len8[5:0];
            sat_ovf = r_overflow;
        end
    end

    // Extension of the current lexeme by one character.
    always_comb begin
        grow_len    = r_token_length;
        grow_ovf    = r_overflow;
        grow_prefix = r_prefix;
        if (len8 >= 8'(LEXEME_CAP)) begin
            grow_ovf = 1'b1;
        end else begin
            for (int i = 0; i < 5; i++) begin
                if (len8 == 8'(i)) begin
                    grow_prefix[8*i +: 8] = i_ch;
                end
            end
            grow_len = r_token_length + 1'b1;
        end
    end

    // Keyword lookup on the stored prefix.
    always_comb begin
        id_kind = K_ID;
        if (!r_overflow) begin
            priority if (len8 == 8'd3 && r_prefix == KW_INT) begin
                id_kind = K_INT;
            end else if (len8 == 8'd5 && r_prefix == KW_FLOAT) begin
                id_kind = K_FLOAT;
            end else if (len8 == 8'd4 && r_prefix == KW_CHAR) begin
                id_kind = K_CHAR;
            end else if (len8 == 8'd5 && r_prefix == KW_PRINT) begin
                id_kind = K_PRINT;
            end else if (len8 == 8'd2 && r_prefix == KW_IF) begin
                id_kind = K_IF;
            end else if (len8 == 8'd5 && r_prefix == KW_WHILE) begin
                id_kind = K_WHILE;
            end else begin
                id_kind = K_ID;
            end
        end
    end

    // Next state and the tokens produced by this character.
    always_comb begin
        n_mode         = r_mode;
        n_pending_op   = r_pending_op;
        n_seen_dot     = r_seen_dot;
        n_token_start  = r_token_start;
        n_token_length = r_token_length;
        n_overflow     = r_overflow;
        n_prefix       = r_prefix;
        n_position     = (r_position == PW'(TEXT_MAX - 1)) ? '0 : r_position + 1'b1;
        close_v        = 1'b0;
        close_tok      = '0;
        do_idle        = 1'b0;
        idle_v         = 1'b0;
        idle_tok       = '0;

        unique case (r_mode)
            M_NUM: begin
                if (is_digit(i_ch) || i_ch == CH_DOT) begin
                    if (i_ch == CH_DOT) begin
                        n_seen_dot = 1'b1;
                    end
                    n_token_length = grow_len;
                    n_overflow     = grow_ovf;
                    n_prefix       = grow_prefix;
                end else begin
                    close_v   = 1'b1;
                    close_tok = mk_token(r_seen_dot ? K_FLOAT : K_NUM, start12, sat_len,
                                         sat_ovf, 1'b0);
                    do_idle   = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_alpha(i_ch) || is_digit(i_ch)) begin
                    n_token_length = grow_len;
                    n_overflow     = grow_ovf;
                    n_prefix       = grow_prefix;
                end else begin
                    close_v   = 1'b1;
                    close_tok = mk_token(id_kind, start12, sat_len, sat_ovf, 1'b0);
                    do_idle   = 1'b1;
                end
            end
            M_QUOTE: begin
                close_v = 1'b1;
                if (i_ch == CH_NUL) begin
                    close_tok = mk_token(K_CHARLIT, start12, 6'd0, 1'b0, 1'b0);
                    do_idle   = 1'b1;
                end else begin
                    close_tok = mk_token(K_CHARLIT, start12, 6'd1, 1'b0, 1'b0);
                    n_mode    = M_SKIP;
                end
            end
            M_SKIP: begin
                if (i_ch == CH_NUL) begin
                    do_idle = 1'b1;
                end else begin
                    n_mode = M_IDLE;
                end
            end
            M_OP: begin
                close_v = 1'b1;
                if (i_ch == CH_EQUAL) begin
                    close_tok = mk_token(pair_kind(r_pending_op), start12, 6'd2, 1'b0, 1'b0);
                    n_mode    = M_IDLE;
                end else begin
                    close_tok = mk_token(single_kind(r_pending_op), start12, 6'd1, 1'b0,
                                         1'b0);
                    do_idle   = 1'b1;
                end
            end
            M_IDLE: begin
                do_idle = 1'b1;
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // The character handled as the start of something new.
        if (do_idle) begin
            n_mode = M_IDLE;
            priority if (i_ch == CH_NUL) begin
                idle_v     = 1'b1;
                idle_tok   = mk_token(K_END, at12, 6'd0, 1'b0, 1'b1);
                n_position = '0;
            end else if (is_space(i_ch)) begin
                idle_v = 1'b0;
            end else if (is_digit(i_ch) || is_alpha(i_ch)) begin
                n_mode         = is_digit(i_ch) ? M_NUM : M_IDENT;
                n_token_start  = r_position;
                n_token_length = LW'(1);
                n_overflow     = 1'b0;
                n_prefix       = 40'(i_ch);
                n_seen_dot     = 1'b0;
            end else if (i_ch == CH_QUOTE) begin
                n_mode        = M_QUOTE;
                n_token_start = r_position;
            end else if (i_ch == CH_EQUAL || i_ch == CH_BANG || i_ch == CH_LT
                         || i_ch == CH_GT) begin
                n_mode        = M_OP;
                n_token_start = r_position;
                priority if (i_ch == CH_EQUAL) begin
                    n_pending_op = OP_EQUAL;
                end else if (i_ch == CH_BANG) begin
                    n_pending_op = OP_BANG;
                end else if (i_ch == CH_LT) begin
                    n_pending_op = OP_LT;
                end else begin
                    n_pending_op = OP_GT;
                end
            end else begin
                idle_v = 1'b1;
                unique case (i_ch)
                    CH_LPAREN: idle_tok = mk_token(K_LPAREN, at12, 6'd1, 1'b0, 1'b0);
                    CH_RPAREN: idle_tok = mk_token(K_RPAREN, at12, 6'd1, 1'b0, 1'b0);
                    CH_LBRACE: idle_tok = mk_token(K_LBRACE, at12, 6'd1, 1'b0, 1'b0);
                    CH_RBRACE: idle_tok = mk_token(K_RBRACE, at12, 6'd1, 1'b0, 1'b0);
                    CH_PLUS:   idle_tok = mk_token(K_PLUS,   at12, 6'd1, 1'b0, 1'b0);
                    CH_MINUS:  idle_tok = mk_token(K_MINUS,  at12, 6'd1, 1'b0, 1'b0);
                    CH_STAR:   idle_tok = mk_token(K_STAR,   at12, 6'd1, 1'b0, 1'b0);
                    CH_SLASH:  idle_tok = mk_token(K_SLASH,  at12, 6'd1, 1'b0, 1'b0);
                    CH_SEMI:   idle_tok = mk_token(K_SEMI,   at12, 6'd1, 1'b0, 1'b0);
                    default:   idle_tok = mk_token(K_END,    at12, 6'd1, 1'b0, 1'b0);
                endcase
            end
        end
    end

    // Pack the closing token first, the character's own token after it.
    always_comb begin
        o_emit.v0 = i_valid && (close_v || idle_v);
        o_emit.v1 = i_valid && close_v && idle_v;
        o_emit.t0 = close_v ? close_tok : idle_tok;
        o_emit.t1 = idle_tok;
    end

    // Lexer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= M_IDLE;
            r_pending_op   <= OP_EQUAL;
            r_seen_dot     <= 1'b0;
            r_token_start  <= '0;
            r_token_length <= '0;
            r_overflow     <= 1'b0;
            r_prefix       <= '0;
            r_position     <= '0;
        end else if (i_valid) begin
            r_mode         <= n_mode;
            r_pending_op   <= n_pending_op;
            r_seen_dot     <= n_seen_dot;
            r_token_start  <= n_token_start;
            r_token_length <= n_token_length;
            r_overflow     <= n_overflow;
            r_prefix       <= n_prefix;
            r_position     <= n_position;
        end
    end

endmodule

// ----- sv/clx_queue.sv -----
module clx_queue
    import clx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_emit  i_emit,
    input  logic   i_ready,
    output logic   o_room,
    output logic   o_valid,
    output t_token o_head
);

    t_token     r_entry [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       pop;
    logic [2:0] push_n;

    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_entry[r_rd_ptr];
    assign o_room  = (r_count <= 3'd2);
    assign pop     = o_valid && i_ready;
    assign push_n  = {2'b00, i_emit.v0} + {2'b00, i_emit.v1};

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[1:0];
            r_rd_ptr <= r_rd_ptr + {1'b0, pop};
            r_count  <= r_count + push_n - {2'b00, pop};
        end
    end

    // Token storage; the second token of a character goes after the first.
    always_ff @(posedge i_clk) begin
        if (i_emit.v0) begin
            r_entry[r_wr_ptr] <= i_emit.t0;
        end
        if (i_emit.v1) begin
            r_entry[r_wr_ptr + 2'd1] <= i_emit.t1;
        end
    end

endmodule

// ----- sv/c_subset_lexer_unit.sv -----
// Streaming lexer for a small C-like language. It takes one source character per cycle
// on i_char (zero ends the text) and returns tokens with kind, start offset, saturated
// length, an overlong flag and a last flag on o_token. A character passes through an
// input register and one pass of lexer logic into the token queue, and each token it
// causes is registered in that queue before it is valid on o_token.
// A character that closes a pending token and also forms one of its own yields two
// tokens; a four-entry token queue absorbs these and drains at one token per cycle
// while o_token.ready is high; input stalls only with fewer than two free entries.
module c_subset_lexer_unit
    import clx_pkg::*;
#(
    parameter int TEXT_MAX   = 4096,
    parameter int LEXEME_CAP = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clx_char_if.sink    i_char,
    clx_token_if.source o_token
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       room;
    logic       advance;
    t_emit      emit;
    t_token     head;

    assign advance      = r_in_valid && room;
    assign i_char.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_ch <= i_char.ch;
        end
    end

    clx_core #(
        .TEXT_MAX   (TEXT_MAX),
        .LEXEME_CAP (LEXEME_CAP)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_ch    (r_ch),
        .o_emit  (emit)
    );

    clx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .i_ready (o_token.ready),
        .o_room  (room),
        .o_valid (o_token.valid),
        .o_head  (head)
    );

    assign o_token.kind      = head.kind;
    assign o_token.start_res = head.start_res;
    assign o_token.length    = head.length;
    assign o_token.overlong  = head.overlong;
    assign o_token.last      = head.last;

endmodule
